@@ hw/rtl/cdsu_pkg.sv @@
// Shared types, constants and calendar helpers for the calendar date step unit.
// No dependencies; imported by cdsu_dow and calendar_date_step_unit.
package cdsu_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int OP_W     = 3;
  localparam int WDAY_W   = 3;
  localparam int MLEN_W   = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef logic [YEAR_W-1:0]   year_t;
  typedef logic [MONTH_W-1:0]  month_t;
  typedef logic [DAY_W-1:0]    day_t;
  typedef logic [HOUR_W-1:0]   hour_t;
  typedef logic [MINUTE_W-1:0] minute_t;
  typedef logic [SECOND_W-1:0] second_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [WDAY_W-1:0]   wday_t;

  typedef struct packed {
    year_t  y;
    month_t m;
    day_t   d;
  } date_t;

  typedef struct packed {
    hour_t   hh;
    minute_t mm;
    second_t ss;
  } hms_t;

  typedef struct packed {
    logic a;
    logic b;
  } dow_en_t;

  localparam op_t OP_NEXT_DAY   = 3'd0;
  localparam op_t OP_PREV_DAY   = 3'd1;
  localparam op_t OP_NEXT_MONTH = 3'd2;
  localparam op_t OP_PREV_MONTH = 3'd3;
  localparam op_t OP_WEEK_START = 3'd4;
  localparam op_t OP_NEXT_WEEK  = 3'd5;
  localparam op_t OP_WEEK_END   = 3'd6;
  localparam op_t OP_QUERY      = 3'd7;

  localparam year_t  YEAR_FIRST = 14'd1;
  localparam year_t  YEAR_LAST  = 14'd9999;
  localparam month_t MON_JAN    = 4'd1;
  localparam month_t MON_FEB    = 4'd2;
  localparam month_t MON_MAR    = 4'd3;
  localparam month_t MON_DEC    = 4'd12;
  localparam wday_t  WD_SUNDAY  = 3'd0;

  localparam hour_t   END_HOUR   = 5'd23;
  localparam minute_t END_MINUTE = 6'd59;
  localparam second_t END_SECOND = 6'd59;

  // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
  localparam int          DIV100_SHIFT = 19;
  localparam int          DIV100_MUL_W = 13;
  localparam int          PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam int          Q100_W       = 8;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;

  function automatic day_t month_days(input month_t m, input logic leap);
    day_t n;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      n = 5'd30;
    end else if (m == MON_FEB) begin
      n = leap ? 5'd29 : 5'd28;
    end else begin
      n = 5'd31;
    end
    return n;
  endfunction

  function automatic logic [2:0] month_offset(input month_t m);
    logic [2:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // 8 is 1 mod 7: fold octal digits twice, then one subtract
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

@@ hw/rtl/cdsu_dow.sv @@
// Two-stage weekday unit (Sakamoto), 0 is Sunday.
// Depends on cdsu_pkg; stage loads are driven by the caller's pipeline control.
module cdsu_dow import cdsu_pkg::*; (
  input  logic    clk,
  input  dow_en_t en,
  input  year_t   year,
  input  month_t  month,
  input  day_t    day,
  output wday_t   wday
);

  year_t             ya_c;
  logic [PROD_W-1:0] prod;
  year_t             ya;
  logic [Q100_W-1:0] q100;
  logic [5:0]        od;
  logic [15:0]       sum;

  assign ya_c = year - YEAR_W'(month < MON_MAR);
  assign prod = PROD_W'(ya_c) * PROD_W'(DIV100_MUL);
  assign sum  = 16'(ya) + 16'(ya[YEAR_W-1:2]) - 16'(q100) + 16'(q100[Q100_W-1:2]) + 16'(od);

  always_ff @(posedge clk) begin
    if (en.a) begin
      ya   <= ya_c;
      q100 <= prod[PROD_W-1:DIV100_SHIFT];
      od   <= 6'(month_offset(month)) + 6'(day);
    end
    if (en.b) begin
      wday <= mod7(sum);
    end
  end

endmodule

@@ hw/rtl/calendar_date_step_unit.sv @@
// Calendar date step unit: steps a Gregorian date by day, month or week and
// reports weekday and month length. Depends on cdsu_pkg and cdsu_dow.
//
// One transfer is accepted every clock cycle unless every stage is held. The six
// register stages are the weekday unit on the input date (two stages, with the
// leap year test beside it), the date step split over two stages (week start,
// then next week start and week end), and the weekday unit on the result date
// (two stages, the last being the output register). A held output stalls only the
// stages behind it; empty stages keep filling. Input dates outside years 1 to
// 9999 or months 1 to 12 or with day 0, and steps that leave years 1 to 9999 echo
// the input with the error flag set and zero weekday and month length.
module calendar_date_step_unit import cdsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // in_year, in_month, in_day, in_hour, in_minute, in_second
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_year, out_month, out_day, out_hour, out_minute, out_second, weekday, month_length
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // range_error
  output logic                  m_axis_tuser
);

  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic en1, en2, en3, en4, en5, en6;

  date_t             in_c;
  hms_t              in_t;
  logic              in_err;
  logic [PROD_W-1:0] in_prod;

  op_t               s1_op;
  date_t             s1_c;
  hms_t              s1_t;
  logic              s1_err;
  logic [Q100_W-1:0] s1_q100;

  year_t             hund;
  logic [6:0]        r100;
  logic              leap_next;

  op_t   s2_op;
  date_t s2_c;
  hms_t  s2_t;
  logic  s2_err;
  logic  s2_leap;
  wday_t wd_in;

  month_t pm;
  day_t   dim_m;
  day_t   dim_pm;
  logic [2:0] k;
  date_t  r3_next;
  logic   err3_next;
  day_t   dims_next;

  op_t   s3_op;
  date_t s3_c;
  hms_t  s3_t;
  logic  s3_err;
  logic  s3_leap;
  date_t s3_r;
  day_t  s3_dims;

  month_t     nm;
  year_t      ny;
  logic       cross_err;
  logic [5:0] t7;
  date_t      nws;
  logic       nws_err;
  date_t      we;
  date_t      r4_next;
  hms_t       t4_next;
  logic       err4_next;
  day_t       mlen4_next;

  date_t r4;
  hms_t  t4;
  logic  err4;
  day_t  mlen4;

  date_t r5;
  hms_t  t5;
  logic  err5;
  day_t  mlen5;

  date_t r6;
  hms_t  t6;
  logic  err6;
  day_t  mlen6;
  wday_t wd_out;

  // handshake: a stage can load when it is empty or the one ahead can load
  assign rdy6 = !v6 || m_axis_tready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign en1 = rdy1 && s_axis_tvalid;
  assign en2 = rdy2 && v1;
  assign en3 = rdy3 && v2;
  assign en4 = rdy4 && v3;
  assign en5 = rdy5 && v4;
  assign en6 = rdy6 && v5;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // stage 1: unpack, check, divide year by 100
  assign in_c.y  = s_axis_tdata[13:0];
  assign in_c.m  = s_axis_tdata[17:14];
  assign in_c.d  = s_axis_tdata[22:18];
  assign in_t.hh = s_axis_tdata[27:23];
  assign in_t.mm = s_axis_tdata[33:28];
  assign in_t.ss = s_axis_tdata[39:34];

  assign in_err  = (in_c.y < YEAR_FIRST) || (in_c.y > YEAR_LAST) || (in_c.m < MON_JAN)
                || (in_c.m > MON_DEC) || (in_c.d == '0);
  assign in_prod = PROD_W'(in_c.y) * PROD_W'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op   <= s_axis_tuser;
      s1_c    <= in_c;
      s1_t    <= in_t;
      s1_err  <= in_err;
      s1_q100 <= in_prod[PROD_W-1:DIV100_SHIFT];
    end
  end

  cdsu_dow u_dow_in (
    .clk   (clk),
    .en    (dow_en_t'{a: en1, b: en2}),
    .year  (in_c.y),
    .month (in_c.m),
    .day   (in_c.d),
    .wday  (wd_in)
  );

  // stage 2: leap year rule
  assign hund      = YEAR_W'(s1_q100) * YEAR_W'(7'd100);
  assign r100      = 7'(s1_c.y - hund);
  assign leap_next = ((s1_c.y[1:0] == 2'b00) && (r100 != '0))
                  || ((r100 == '0) && (s1_q100[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op   <= s1_op;
      s2_c    <= s1_c;
      s2_t    <= s1_t;
      s2_err  <= s1_err;
      s2_leap <= leap_next;
    end
  end

  // stage 3: day and month steps, week start
  assign pm     = (s2_c.m == MON_JAN) ? MON_DEC : s2_c.m - 4'd1;
  assign dim_m  = month_days(s2_c.m, s2_leap);
  assign dim_pm = month_days(pm, s2_leap);
  assign k      = (wd_in == WD_SUNDAY) ? 3'd6 : wd_in - 3'd1;

  always_comb begin
    r3_next   = s2_c;
    err3_next = s2_err;
    dims_next = dim_m;
    if (!s2_err) begin
      case (s2_op)
        OP_NEXT_DAY: begin
          if (s2_c.d >= dim_m) begin
            r3_next.d = 5'd1;
            if (s2_c.m == MON_DEC) begin
              r3_next.m = MON_JAN;
              if (s2_c.y == YEAR_LAST) err3_next = 1'b1;
              else r3_next.y = s2_c.y + 14'd1;
            end else begin
              r3_next.m = s2_c.m + 4'd1;
            end
          end else begin
            r3_next.d = s2_c.d + 5'd1;
          end
        end
        OP_PREV_DAY: begin
          if (s2_c.d == 5'd1) begin
            r3_next.m = pm;
            r3_next.d = dim_pm;
            if (s2_c.m == MON_JAN) begin
              if (s2_c.y == YEAR_FIRST) err3_next = 1'b1;
              else r3_next.y = s2_c.y - 14'd1;
            end
          end else begin
            r3_next.d = s2_c.d - 5'd1;
          end
        end
        OP_NEXT_MONTH: begin
          if (s2_c.m == MON_DEC) begin
            r3_next.m = MON_JAN;
            if (s2_c.y == YEAR_LAST) err3_next = 1'b1;
            else r3_next.y = s2_c.y + 14'd1;
          end else begin
            r3_next.m = s2_c.m + 4'd1;
          end
        end
        OP_PREV_MONTH: begin
          if (s2_c.m == MON_JAN) begin
            r3_next.m = MON_DEC;
            if (s2_c.y == YEAR_FIRST) err3_next = 1'b1;
            else r3_next.y = s2_c.y - 14'd1;
          end else begin
            r3_next.m = s2_c.m - 4'd1;
          end
        end
        OP_WEEK_START, OP_NEXT_WEEK, OP_WEEK_END: begin
          if (s2_c.d > 5'(k)) begin
            r3_next.d = s2_c.d - 5'(k);
          end else begin
            r3_next.m = pm;
            r3_next.d = dim_pm - (5'(k) - s2_c.d);
            dims_next = dim_pm;
            if (s2_c.m == MON_JAN) begin
              if (s2_c.y == YEAR_FIRST) err3_next = 1'b1;
              else r3_next.y = s2_c.y - 14'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op   <= s2_op;
      s3_c    <= s2_c;
      s3_t    <= s2_t;
      s3_err  <= err3_next;
      s3_leap <= s2_leap;
      s3_r    <= r3_next;
      s3_dims <= dims_next;
    end
  end

  // stage 4: next week start and week end from the week start, error echo
  assign nm        = (s3_r.m == MON_DEC) ? MON_JAN : s3_r.m + 4'd1;
  assign ny        = (s3_r.m == MON_DEC) ? s3_r.y + 14'd1 : s3_r.y;
  assign cross_err = (s3_r.m == MON_DEC) && (s3_r.y == YEAR_LAST);
  assign t7        = 6'(s3_r.d) + 6'd7;

  always_comb begin
    nws_err = 1'b0;
    if (t7 <= 6'(s3_dims)) begin
      nws.y = s3_r.y;
      nws.m = s3_r.m;
      nws.d = t7[DAY_W-1:0];
    end else begin
      nws.y   = ny;
      nws.m   = nm;
      nws_err = cross_err;
      if (s3_r.d > s3_dims) nws.d = s3_r.d - s3_dims;
      else nws.d = 5'(t7 - 6'(s3_dims));
    end
    if (nws.d == 5'd1) begin
      we.y = s3_r.y;
      we.m = s3_r.m;
      we.d = s3_dims;
    end else begin
      we.y = nws.y;
      we.m = nws.m;
      we.d = nws.d - 5'd1;
    end
  end

  always_comb begin
    r4_next   = s3_r;
    t4_next   = s3_t;
    err4_next = s3_err;
    case (s3_op)
      OP_WEEK_START: begin
        t4_next = '0;
      end
      OP_NEXT_WEEK: begin
        r4_next   = nws;
        err4_next = s3_err || nws_err;
        t4_next   = '0;
      end
      OP_WEEK_END: begin
        r4_next   = we;
        err4_next = s3_err || nws_err;
        t4_next   = '{hh: END_HOUR, mm: END_MINUTE, ss: END_SECOND};
      end
      default: begin
      end
    endcase
    if (err4_next) begin
      r4_next    = s3_c;
      t4_next    = s3_t;
      mlen4_next = '0;
    end else begin
      mlen4_next = month_days(r4_next.m, s3_leap);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      r4    <= r4_next;
      t4    <= t4_next;
      err4  <= err4_next;
      mlen4 <= mlen4_next;
    end
  end

  // stages 5 and 6: weekday of the result, output register
  cdsu_dow u_dow_out (
    .clk   (clk),
    .en    (dow_en_t'{a: en5, b: en6}),
    .year  (r4.y),
    .month (r4.m),
    .day   (r4.d),
    .wday  (wd_out)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      r5    <= r4;
      t5    <= t4;
      err5  <= err4;
      mlen5 <= mlen4;
    end
    if (en6) begin
      r6    <= r5;
      t6    <= t5;
      err6  <= err5;
      mlen6 <= mlen5;
    end
  end

  assign m_axis_tdata = {mlen6, (err6 ? WD_SUNDAY : wd_out), t6.ss, t6.mm, t6.hh,
                         r6.d, r6.m, r6.y};
  assign m_axis_tuser = err6;

  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    (v6 && !err6) |-> ((mlen6 >= 5'd28) && (mlen6 <= 5'd31) && (wd_out <= 3'd6)
                       && (r6.d != '0) && (r6.m >= MON_JAN) && (r6.m <= MON_DEC)))
    else $error("result date out of range without error flag");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_axis_tready)
    else $error("input refused with first stage empty");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && v6 && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while every stage is held");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for calendar_date_step_unit: drives date steps over the
// input stream and checks every result against a built-in calendar predictor.
// Depends on cdsu_pkg and the RTL of calendar_date_step_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdsu_pkg::*;

  localparam int WATCHDOG   = 2000;
  localparam int PHASES     = 5;
  localparam int PHASE_REQS = 260;

  // tdata layout of the input stream, lowest field last
  typedef struct packed {
    second_t ss;
    minute_t mm;
    hour_t   hh;
    day_t    d;
    month_t  m;
    year_t   y;
  } stamp_t;

  typedef struct {
    op_t    op;
    stamp_t at;
  } request_t;

  // {tuser, tdata} layout of the output stream
  typedef struct packed {
    logic              bad;
    logic [MLEN_W-1:0] mlen;
    wday_t             wday;
    second_t           ss;
    minute_t           mm;
    hour_t             hh;
    day_t              d;
    month_t            m;
    year_t             y;
  } answer_t;

  localparam int unsigned MONTH_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
  localparam int SEND_IDLE [PHASES]  = '{0, 71, 0, 33, 0};
  localparam int RECV_STALL [PHASES] = '{0, 0, 71, 33, 0};

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  request_t dates_to_send [$];
  answer_t  expected_dates [$];
  request_t on_wire;
  int       send_idle  = 0;
  int       recv_stall = 0;
  int       dates_sent = 0;
  int       dates_checked = 0;
  int       dates_flagged = 0;
  int       errors = 0;
  int       quiet = 0;

  calendar_date_step_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic int unsigned month_len(int unsigned y, int unsigned m);
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    if (m == MON_FEB) begin
      return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
    end
    return 31;
  endfunction

  function automatic int unsigned weekday_of(int unsigned y, int unsigned m, int unsigned d);
    int unsigned yy;
    yy = y - ((m < MON_MAR) ? 1 : 0);
    return (yy + yy / 4 - yy / 100 + yy / 400 + MONTH_SHIFT[m - 1] + d) % 7;
  endfunction

  function automatic void fwd_day(inout int unsigned y, inout int unsigned m,
                                  inout int unsigned d, inout bit bad);
    d++;
    if (d > month_len(y, m)) begin
      d = 1;
      m++;
      if (m > MON_DEC) begin
        m = MON_JAN;
        if (y >= YEAR_LAST) bad = 1'b1;
        else y++;
      end
    end
  endfunction

  function automatic void back_day(inout int unsigned y, inout int unsigned m,
                                   inout int unsigned d, inout bit bad);
    d--;
    if (d == 0) begin
      m--;
      if (m == 0) begin
        m = MON_DEC;
        if (y <= YEAR_FIRST) bad = 1'b1;
        else y--;
      end
      d = month_len(y, m);
    end
  endfunction

  // walk back to Monday
  function automatic void to_monday(inout int unsigned y, inout int unsigned m,
                                    inout int unsigned d, inout bit bad);
    for (int i = 0; i < 7 && !bad && weekday_of(y, m, d) != 1; i++) begin
      back_day(y, m, d, bad);
    end
  endfunction

  // walk forward to the Monday after the current week start
  function automatic void to_next_monday(inout int unsigned y, inout int unsigned m,
                                         inout int unsigned d, inout bit bad);
    to_monday(y, m, d, bad);
    if (bad) return;
    fwd_day(y, m, d, bad);
    for (int i = 0; i < 8 && !bad && weekday_of(y, m, d) != 1; i++) begin
      fwd_day(y, m, d, bad);
    end
  endfunction

  function automatic answer_t step_date(request_t rq);
    int unsigned y, m, d, hh, mm, ss;
    bit          bad;
    answer_t     a;
    y  = rq.at.y;
    m  = rq.at.m;
    d  = rq.at.d;
    hh = rq.at.hh;
    mm = rq.at.mm;
    ss = rq.at.ss;
    bad = (y < YEAR_FIRST || y > YEAR_LAST || m < MON_JAN || m > MON_DEC || d < 1);
    if (!bad) begin
      case (rq.op)
        OP_NEXT_DAY: fwd_day(y, m, d, bad);
        OP_PREV_DAY: back_day(y, m, d, bad);
        OP_NEXT_MONTH: begin
          if (m == MON_DEC) begin
            m = MON_JAN;
            if (y >= YEAR_LAST) bad = 1'b1;
            else y++;
          end else begin
            m++;
          end
        end
        OP_PREV_MONTH: begin
          if (m == MON_JAN) begin
            m = MON_DEC;
            if (y <= YEAR_FIRST) bad = 1'b1;
            else y--;
          end else begin
            m--;
          end
        end
        OP_WEEK_START: begin
          to_monday(y, m, d, bad);
          hh = 0;
          mm = 0;
          ss = 0;
        end
        OP_NEXT_WEEK: begin
          to_next_monday(y, m, d, bad);
          hh = 0;
          mm = 0;
          ss = 0;
        end
        OP_WEEK_END: begin
          to_next_monday(y, m, d, bad);
          if (!bad) back_day(y, m, d, bad);
          hh = END_HOUR;
          mm = END_MINUTE;
          ss = END_SECOND;
        end
        default: ;
      endcase
    end
    a = '0;
    if (bad) begin
      a.y   = rq.at.y;
      a.m   = rq.at.m;
      a.d   = rq.at.d;
      a.hh  = rq.at.hh;
      a.mm  = rq.at.mm;
      a.ss  = rq.at.ss;
      a.bad = 1'b1;
    end else begin
      a.y    = year_t'(y);
      a.m    = month_t'(m);
      a.d    = day_t'(d);
      a.hh   = hour_t'(hh);
      a.mm   = minute_t'(mm);
      a.ss   = second_t'(ss);
      a.wday = wday_t'(weekday_of(y, m, d));
      a.mlen = MLEN_W'(month_len(y, m));
    end
    return a;
  endfunction

  function automatic string show(answer_t a);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wday %0d len %0d err %0d",
                     a.y, a.m, a.d, a.hh, a.mm, a.ss, a.wday, a.mlen, a.bad);
  endfunction

  task automatic queue_date(op_t op, int y, int m, int d, int hh, int mm, int ss);
    request_t r;
    r.op    = op;
    r.at.y  = year_t'(y);
    r.at.m  = month_t'(m);
    r.at.d  = day_t'(d);
    r.at.hh = hour_t'(hh);
    r.at.mm = minute_t'(mm);
    r.at.ss = second_t'(ss);
    dates_to_send.insert(dates_to_send.size(), r);
  endtask

  // mostly legal dates, weighted towards month ends and the edges of the year range
  function automatic request_t random_request();
    request_t r;
    int       sel;
    r.op = op_t'($urandom_range(7));
    sel = $urandom_range(99);
    if (sel < 8) begin
      r.at.y = year_t'($urandom_range(3, 1));
      r.at.m = $urandom_range(1) ? MON_JAN : month_t'($urandom_range(12, 1));
    end else if (sel < 16) begin
      r.at.y = year_t'($urandom_range(9999, 9997));
      r.at.m = $urandom_range(1) ? MON_DEC : month_t'($urandom_range(12, 1));
    end else if (sel < 21) begin
      r.at.y = year_t'($urandom);
      r.at.m = month_t'($urandom);
    end else begin
      r.at.y = year_t'($urandom_range(9999, 1));
      r.at.m = month_t'($urandom_range(12, 1));
    end
    sel = $urandom_range(9);
    if (sel < 4) r.at.d = day_t'($urandom_range(31, 26));
    else if (sel < 6) r.at.d = day_t'($urandom_range(3, 1));
    else r.at.d = day_t'($urandom);
    if ($urandom_range(4) == 0) begin
      r.at.hh = hour_t'($urandom);
      r.at.mm = minute_t'($urandom);
      r.at.ss = second_t'($urandom);
    end else begin
      r.at.hh = hour_t'($urandom_range(23));
      r.at.mm = minute_t'($urandom_range(59));
      r.at.ss = second_t'($urandom_range(59));
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_dates.insert(expected_dates.size(), step_date(on_wire));
        dates_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (dates_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
          on_wire = dates_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_wire.at;
          s_axis_tuser  <= on_wire.op;
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
          s_axis_tuser  <= OP_W'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    answer_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = answer_t'({m_axis_tuser, m_axis_tdata});
        if (expected_dates.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %s", $time, show(got));
        end else begin
          want = expected_dates.pop_front();
          dates_checked++;
          if (want.bad) dates_flagged++;
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected %s actual %s", $time, show(want), show(got));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("testbench: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      send_idle  = SEND_IDLE[p];
      recv_stall = RECV_STALL[p];
      if (p == 0) begin
        queue_date(OP_QUERY,      9999, 12, 31, 31, 63, 63);
        queue_date(OP_QUERY,         1,  1,  1,  0,  0,  0);
        queue_date(OP_NEXT_DAY,   9999, 12, 31, 12, 30, 45);
        queue_date(OP_PREV_DAY,      1,  1,  1,  7,  8,  9);
        queue_date(OP_NEXT_MONTH, 9999, 12, 15, 23, 59, 59);
        queue_date(OP_PREV_MONTH,    1,  1, 10,  1,  2,  3);
        queue_date(OP_WEEK_END,   9999, 12, 31,  5,  5,  5);
        queue_date(OP_NEXT_WEEK,  9999, 12, 27, 10, 20, 30);
        queue_date(OP_WEEK_START,    1,  1,  3, 16, 40, 50);
        queue_date(OP_WEEK_START,    1,  1,  1, 31, 63, 63);
        queue_date(OP_QUERY,         0,  5,  5,  1,  1,  1);
        queue_date(OP_NEXT_DAY,  16383,  6,  6,  2,  2,  2);
        queue_date(OP_PREV_DAY,   2020,  0, 10,  3,  3,  3);
        queue_date(OP_NEXT_MONTH, 2020, 13, 10,  4,  4,  4);
        queue_date(OP_PREV_MONTH, 2020, 15, 10,  5,  5,  5);
        queue_date(OP_WEEK_START, 2020,  6,  0,  6,  6,  6);
        queue_date(OP_NEXT_DAY,   1900,  2, 28, 11, 11, 11);
        queue_date(OP_NEXT_DAY,   2000,  2, 28, 12, 12, 12);
        queue_date(OP_PREV_DAY,   2024,  3,  1, 13, 13, 13);
        queue_date(OP_PREV_DAY,   2100,  3,  1, 14, 14, 14);
        queue_date(OP_NEXT_MONTH, 2023,  1, 31, 15, 15, 15);
        queue_date(OP_WEEK_START, 2023,  2, 31, 17, 17, 17);
        queue_date(OP_WEEK_END,   2023,  2, 31, 18, 18, 18);
        queue_date(OP_NEXT_WEEK,  2024, 12, 29, 19, 19, 19);
        queue_date(OP_WEEK_END,   2024, 12, 30, 20, 20, 20);
      end
      repeat (PHASE_REQS) dates_to_send.insert(dates_to_send.size(), random_request());
      while (dates_to_send.size() > 0) @(negedge clk);
    end
    while (dates_to_send.size() > 0 || s_axis_tvalid || expected_dates.size() > 0) begin
      @(negedge clk);
    end
    repeat (24) @(negedge clk);
    $display("%0d date steps sent and %0d checked across all operations and four idle patterns,",
             dates_sent, dates_checked);
    $display("%0d of them out of range or invalid, %0d mismatches", dates_flagged, errors);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cdsu_pkg.sv
hw/rtl/cdsu_dow.sv
hw/rtl/calendar_date_step_unit.sv
verif/testbench.sv
